// ===== design/vadpcm_pkg.sv =====
`default_nettype none
package vadpcm_pkg;

  localparam int MaxPredictorsDefault = 16;

  typedef enum logic [1:0] {
    MODE_BOOK  = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_START = 2'd2,
    MODE_NONE  = 2'd3
  } in_mode_t;

  typedef enum logic [1:0] {
    REG_CODEC = 2'd0,
    REG_PCOUNT = 2'd1,
    REG_LIMIT = 2'd2,
    REG_NONE = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_BOOK  = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_START = 2'd2
  } cmd_kind_t;

  // command passed from front to back
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  book_index;
    logic [15:0] book_value;
    logic [7:0]  data_byte;
  } cmd_t;

endpackage
`default_nettype wire

// ===== design/vector_adpcm_sample_decoder.sv =====
// each sample of a frame byte: its residual is stored, then its i+3 terms
// (i its index in the half) are summed one at a time, each with a book read,
// a multiply and an add; a byte, book write, start or header is taken only
// when the back is idle and holds no result
// reset: rst is synchronous; stream state and registers clear, book is undefined
`default_nettype none
module vector_adpcm_sample_decoder #(
  parameter int MAX_PREDICTORS = vadpcm_pkg::MaxPredictorsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         mode,
  input  wire logic [7:0]         book_index,
  input  wire logic signed [15:0] book_value,
  input  wire logic [7:0]         data_byte,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      pcm_sample,
  output logic                    last,
  output logic                    error,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);
  import vadpcm_pkg::*;

  logic        codec_mode;
  logic [4:0]  predictor_count;
  logic [23:0] sample_limit;
  cmd_t        cmd;
  logic        cmd_valid, cmd_take, res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode <= 1'b0;
      predictor_count <= 5'd1;
      sample_limit <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_CODEC:  codec_mode <= cfg_data[0];
        REG_PCOUNT: predictor_count <= cfg_data[4:0];
        REG_LIMIT:  sample_limit <= cfg_data;
        REG_NONE:   ;
      endcase
    end
  end

  vadpcm_front u_front (
    .clk, .rst, .push, .full, .mode, .book_index, .book_value, .data_byte,
    .cmd, .cmd_valid, .cmd_take
  );

  vadpcm_back #(.MAX_PREDICTORS(MAX_PREDICTORS)) u_back (
    .clk, .rst, .cmd, .cmd_valid, .cmd_take, .codec_mode, .predictor_count,
    .sample_limit, .res_valid, .res_ready(pop), .res_pcm(pcm_sample),
    .res_last(last), .res_error(error)
  );

  assign empty = !res_valid;

endmodule
`default_nettype wire

// ===== design/vadpcm_front.sv =====
`default_nettype none
module vadpcm_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        mode,
  input  wire logic [7:0]        book_index,
  input  wire logic [15:0]       book_value,
  input  wire logic [7:0]        data_byte,
  output vadpcm_pkg::cmd_t       cmd,
  output logic                   cmd_valid,
  input  wire logic              cmd_take
);
  import vadpcm_pkg::*;

  // two-entry command queue
  cmd_t       q [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       wr_en, rd_en;
  cmd_t       in_cmd;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  // mode 3 is dropped here
  assign wr_en = push && !full && (mode != MODE_NONE);
  assign rd_en = cmd_take && cmd_valid;

  always_comb begin
    in_cmd.kind       = cmd_kind_t'(mode);
    in_cmd.book_index = book_index;
    in_cmd.book_value = book_value;
    in_cmd.data_byte  = data_byte;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) full |-> !wr_en)
    else $error("write into full queue");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !rd_en)
    else $error("read from empty queue");

endmodule
`default_nettype wire

// ===== design/vadpcm_back.sv =====
`default_nettype none
module vadpcm_back #(
  parameter int MAX_PREDICTORS = vadpcm_pkg::MaxPredictorsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire vadpcm_pkg::cmd_t   cmd,
  input  wire logic               cmd_valid,
  output logic                    cmd_take,
  input  wire logic               codec_mode,
  input  wire logic [4:0]         predictor_count,
  input  wire logic [23:0]        sample_limit,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output logic signed [15:0]      res_pcm,
  output logic                    res_last,
  output logic                    res_error
);
  import vadpcm_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RES  = 6'b000010,
    ST_TERM = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_SUM  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state;

  logic signed [15:0] book_mem [256];
  logic signed [15:0] rd_data;
  logic [7:0]         rd_addr;
  logic               rd_en;

  logic signed [15:0] history [2];
  logic signed [15:0] resbuf [8];
  logic [3:0]  byte_position, frame_predictor, frame_shift;
  logic [23:0] samples_emitted;
  logic        error_flag;

  logic [7:0]  cur_byte;
  logic [1:0]  j;        // residual within the byte
  logic [3:0]  t;        // term index 0..i+2
  logic [2:0]  si;       // sample index in half
  logic signed [15:0] sixth;
  logic signed [15:0] op_b;
  logic signed [31:0] prod;
  logic signed [40:0] acc;
  logic        out_v, out_last, out_err;
  logic signed [15:0] out_pcm;

  assign res_valid = out_v;
  assign res_pcm   = out_pcm;
  assign res_last  = out_last;
  assign res_error = out_err;

  logic [4:0] cap;
  assign cap = (predictor_count < 5'(MAX_PREDICTORS)) ? predictor_count
                                                      : 5'(MAX_PREDICTORS);
  logic limit_hit;
  assign limit_hit = (sample_limit != 24'd0) && (samples_emitted >= sample_limit);

  logic [3:0] nres;
  assign nres = codec_mode ? 4'd4 : 4'd8;
  logic [3:0] smax, sh;
  assign smax = codec_mode ? 4'd14 : 4'd12;
  assign sh   = (frame_shift < smax) ? frame_shift : smax;

  logic [1:0] per_last;
  assign per_last = codec_mode ? 2'd3 : 2'd1;

  // residual field and scaled value
  logic signed [15:0] rv, rscaled;
  logic [2:0] new_i;
  always_comb begin
    if (codec_mode) begin
      rv = 16'(signed'(2'(cur_byte >> (3'd6 - {j, 1'b0}))));
      new_i = 3'({byte_position - 4'd1, 2'b00}) + 3'(j);
    end else begin
      rv = 16'(signed'(4'(cur_byte >> (3'd4 - {j[0], 2'b00}))));
      new_i = 3'({byte_position - 4'd1, 1'b0}) + 3'(j);
    end
    rscaled = rv <<< sh;
  end

  // terms: t=0 A[i]*h0, t=1 B[i]*h1, t=2 2048*r[i], t=3+p B[i-p-1]*r[p]
  logic [2:0] p_idx;
  assign p_idx = 3'(t - 4'd3);
  always_comb begin
    rd_addr = {frame_predictor, 4'd0};
    op_b    = 16'sd0;
    if (t == 4'd0) begin
      rd_addr = {frame_predictor, 1'b0, si};
      op_b    = history[0];
    end else if (t == 4'd1) begin
      rd_addr = {frame_predictor, 1'b1, si};
      op_b    = history[1];
    end else if (t == 4'd2) begin
      op_b = resbuf[si];
    end else begin
      rd_addr = {frame_predictor, 1'b1, 3'(si - p_idx - 3'd1)};
      op_b    = resbuf[p_idx];
    end
  end

  logic [3:0] t_end;
  assign t_end = 4'(si) + 4'd2;

  logic signed [40:0] q;
  logic signed [15:0] sat;
  always_comb begin
    q = acc >>> 11;
    if (q < -41'sd32768) sat = -16'sd32768;
    else if (q > 41'sd32767) sat = 16'sd32767;
    else sat = q[15:0];
  end

  assign cmd_take = (state == ST_IDLE) && cmd_valid && !out_v;
  assign rd_en = 1'b1;

  always_ff @(posedge clk) begin
    if (cmd_take && cmd.kind == CMD_BOOK) book_mem[cmd.book_index] <= cmd.book_value;
    if (rd_en) rd_data <= book_mem[rd_addr];
  end

  logic t_is2_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_v <= 1'b0;
      history[0] <= '0; history[1] <= '0;
      for (int k = 0; k < 8; k++) resbuf[k] <= '0;
      byte_position <= '0; frame_predictor <= '0; frame_shift <= '0;
      samples_emitted <= '0; error_flag <= 1'b0;
      j <= '0; t <= '0; si <= '0;
    end else begin
      // a sample loaded in ST_OUT replaces the one being popped
      if (out_v && res_ready && !(state == ST_OUT && !limit_hit)) out_v <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd_take) begin
            cur_byte <= cmd.data_byte;
            if (cmd.kind == CMD_START) begin
              history[0] <= '0; history[1] <= '0;
              for (int k = 0; k < 8; k++) resbuf[k] <= '0;
              byte_position <= '0; frame_predictor <= '0; frame_shift <= '0;
              samples_emitted <= '0; error_flag <= 1'b0;
            end else if (cmd.kind == CMD_BYTE) begin
              if (error_flag) begin
                out_v <= 1'b1; out_pcm <= '0; out_last <= 1'b1; out_err <= 1'b1;
              end else if (!limit_hit) begin
                if (byte_position == 4'd0 || byte_position > nres) begin
                  byte_position <= 4'd0;
                  if ({1'b0, cmd.data_byte[3:0]} >= cap) begin
                    error_flag <= 1'b1;
                    out_v <= 1'b1; out_pcm <= '0; out_last <= 1'b1; out_err <= 1'b1;
                  end else begin
                    frame_predictor <= cmd.data_byte[3:0];
                    frame_shift <= cmd.data_byte[7:4];
                    byte_position <= 4'd1;
                  end
                end else begin
                  j <= '0;
                  state <= ST_RES;
                end
              end
            end
          end
        end
        ST_RES: begin
          resbuf[new_i] <= rscaled;
          si <= new_i;
          t <= '0;
          acc <= '0;
          state <= ST_TERM;
        end
        ST_TERM: begin
          // book read issued this cycle for term t
          t_is2_d <= (t == 4'd2);
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod <= t_is2_d ? 32'(op_b) <<< 11 : rd_data * op_b;
          state <= ST_SUM;
        end
        ST_SUM: begin
          acc <= acc + 41'(prod);
          if (t == t_end) begin
            state <= ST_OUT;
          end else begin
            t <= t + 4'd1;
            state <= ST_TERM;
          end
        end
        ST_OUT: begin
          if (!out_v || res_ready) begin
            if (!limit_hit) begin
              out_v <= 1'b1; out_pcm <= sat; out_err <= 1'b0;
              out_last <= (j == per_last) ||
                          ((sample_limit != 24'd0) &&
                           (samples_emitted + 24'd1 >= sample_limit));
              samples_emitted <= samples_emitted + 24'd1;
            end
            if (si == 3'd6) sixth <= sat;
            if (si == 3'd7) begin
              history[0] <= sixth; history[1] <= sat;
            end
            if (j == per_last) begin
              byte_position <= (byte_position >= nres) ? 4'd0 : byte_position + 4'd1;
              state <= ST_IDLE;
            end else begin
              j <= j + 2'd1;
              state <= ST_RES;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !limit_hit && (out_v && !res_ready)) |=> state == ST_OUT)
    else $error("result overwritten");
  assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> state == ST_IDLE)
    else $error("command taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    (out_v && out_err) |-> (out_pcm == 16'sd0 && out_last))
    else $error("malformed error result");

endmodule
`default_nettype wire
